// ----- rtl/core/gwms_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gwms_pkg
// Shared constants and types for the guided window match search block.
// ----------------------------------------------------------------------------
package gwms_pkg;

  localparam int MaxWidth   = 512;
  localparam int MaxHeight  = 512;
  localparam int RowsAbove  = 20;
  localparam int RowsBelow  = 20;
  localparam int ColsLeft   = 100;
  localparam int ColsRight  = 10;

  localparam int XW    = $clog2(MaxWidth);
  localparam int YW    = $clog2(MaxHeight);
  localparam int AW    = XW + YW;
  localparam int CW    = 11;               // signed scan coordinate width
  localparam int ERRW  = 25;

  localparam logic [ERRW-1:0] ERR_INF = '1;

  localparam logic [2:0] REG_WIDTH  = 3'd0;
  localparam logic [2:0] REG_HEIGHT = 3'd1;
  localparam logic [2:0] REG_CW     = 3'd2;
  localparam logic [2:0] REG_PW     = 3'd3;
  localparam logic [2:0] REG_EW     = 3'd4;

  // controller -> datapath
  typedef struct packed {
    logic load;      // write entry at input address
    logic init;      // capture query, set scan origin
    logic rd;        // issue read for current scan position
    logic adv;       // step scan position
    logic fin_rd;    // read entry at query position (empty window)
    logic done;      // drive result
  } gwms_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic last;      // current scan position is the last one
  } gwms_sts_t;

  function automatic logic [9:0] term_sum(input logic [23:0] a, input logic [23:0] b);
    logic [9:0] s;
    s = 10'd0;
    for (int i = 0; i < 3; i++) begin
      if (a[i*8 +: 8] > b[i*8 +: 8]) s = s + 10'(a[i*8 +: 8] - b[i*8 +: 8]);
      else                           s = s + 10'(b[i*8 +: 8] - a[i*8 +: 8]);
    end
    return s;
  endfunction

endpackage

// ----- rtl/core/gwms_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gwms_ctrl
// Sequencer: load, window scan and result phases.
// ----------------------------------------------------------------------------
module gwms_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic                in_operation,
  input  gwms_pkg::gwms_sts_t sts,
  output gwms_pkg::gwms_cmd_t cmd,
  output logic                busy
);
  import gwms_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SCAN  = 3'd1;
  localparam logic [2:0] S_DRAIN = 3'd2;
  localparam logic [2:0] S_FIN   = 3'd3;
  localparam logic [2:0] S_OUT   = 3'd4;

  logic [2:0] state_r, state_nxt;
  logic [2:0] drain_r, drain_nxt;

  assign busy = (state_r != S_IDLE);

  always_comb begin
    state_nxt = state_r;
    drain_nxt = drain_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          if (in_operation) begin
            cmd.init  = 1'b1;
            state_nxt = S_SCAN;
          end else begin
            cmd.load = 1'b1;
          end
        end
      end
      S_SCAN: begin
        cmd.rd  = 1'b1;
        cmd.adv = 1'b1;
        if (sts.last) begin
          state_nxt = S_DRAIN;
          drain_nxt = 3'd0;
        end
      end
      S_DRAIN: begin
        drain_nxt = drain_r + 3'd1;
        if (drain_r == 3'd3) state_nxt = S_FIN;
      end
      S_FIN: begin
        cmd.fin_rd = 1'b1;
        drain_nxt  = 3'd0;
        state_nxt  = S_OUT;
      end
      S_OUT: begin
        drain_nxt = drain_r + 3'd1;
        if (drain_r == 3'd1) begin
          cmd.done  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      drain_r <= 3'd0;
    end else begin
      state_r <= state_nxt;
      drain_r <= drain_nxt;
    end
  end

endmodule

// ----- rtl/core/gwms_dp.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gwms_dp
// Source store, window scan counters, error pipeline and minimum tracking.
// ----------------------------------------------------------------------------
module gwms_dp (
  input  logic                clk,
  input  logic                rst_n,
  input  gwms_pkg::gwms_cmd_t cmd,
  output gwms_pkg::gwms_sts_t sts,
  input  logic [9:0]          cfg_w,
  input  logic [9:0]          cfg_h,
  input  logic [3:0]          cfg_cw,
  input  logic [3:0]          cfg_pw,
  input  logic [3:0]          cfg_ew,
  input  logic [8:0]          in_pixel_x,
  input  logic [8:0]          in_pixel_y,
  input  logic [23:0]         in_style_rgb,
  input  logic [23:0]         in_color_rgb,
  input  logic [23:0]         in_position_rgb,
  input  logic [23:0]         in_edge_rgb,
  output logic                out_valid,
  output logic [8:0]          out_match_x,
  output logic [8:0]          out_match_y,
  output logic [23:0]         out_match_rgb,
  output logic [24:0]         out_match_error
);
  import gwms_pkg::*;

  logic [95:0] mem [0:(1<<AW)-1];
  logic [95:0] rdata_r;

  logic [XW-1:0] qx_r;
  logic [YW-1:0] qy_r;
  logic [23:0]   ts_r, tc_r, tp_r, te_r;
  logic [9:0]    w_r, h_r;
  logic signed [CW-1:0] px_r, py_r;

  logic [XW-1:0] ax;
  logic [YW-1:0] ay;
  logic          in_win;
  logic          wr_en;
  logic [AW-1:0] waddr, raddr;

  // pipeline: s1 read, s2 sums, s3 squares, s4 weights+add, s5 compare
  logic          v1_r, v2_r, v3_r, v4_r;
  logic [XW-1:0] x1_r, x2_r, x3_r, x4_r;
  logic [YW-1:0] y1_r, y2_r, y3_r, y4_r;
  logic [23:0]   rgb2_r, rgb3_r, rgb4_r;
  logic [9:0]    s_s_r, s_c_r, s_p_r, s_e_r;
  logic [19:0]   q_s_r, q_c_r, q_p_r, q_e_r;
  logic [ERRW-1:0] e4_r;

  logic            found_r;
  logic [ERRW-1:0] best_r;
  logic [XW-1:0]   bx_r;
  logic [YW-1:0]   by_r;
  logic [23:0]     brgb_r;
  logic            fin_r;

  assign sts.last = (px_r == CW'(qx_r) + CW'(ColsRight - 1)) &&
                    (py_r == CW'(qy_r) + CW'(RowsBelow - 1));

  assign in_win = (px_r >= 0) && (py_r >= 0) &&
                  (px_r < $signed({1'b0, w_r})) && (py_r < $signed({1'b0, h_r}));
  assign ax = px_r[XW-1:0];
  assign ay = py_r[YW-1:0];

  assign wr_en = cmd.load && ({1'b0, in_pixel_x} < 10'(MaxWidth)) &&
                 ({1'b0, in_pixel_y} < 10'(MaxHeight));
  assign waddr = {in_pixel_y[YW-1:0], in_pixel_x[XW-1:0]};
  assign raddr = cmd.fin_rd ? {qy_r, qx_r} : {ay, ax};

  always_ff @(posedge clk) begin
    if (wr_en) mem[waddr] <= {in_style_rgb, in_color_rgb, in_position_rgb, in_edge_rgb};
    rdata_r <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (cmd.init) begin
      qx_r <= in_pixel_x[XW-1:0];
      qy_r <= in_pixel_y[YW-1:0];
      ts_r <= in_style_rgb;
      tc_r <= in_color_rgb;
      tp_r <= in_position_rgb;
      te_r <= in_edge_rgb;
      w_r  <= (cfg_w > 10'(MaxWidth))  ? 10'(MaxWidth)  : cfg_w;
      h_r  <= (cfg_h > 10'(MaxHeight)) ? 10'(MaxHeight) : cfg_h;
      px_r <= CW'(in_pixel_x) - CW'(ColsLeft);
      py_r <= CW'(in_pixel_y) - CW'(RowsAbove);
    end else if (cmd.adv) begin
      if (px_r == CW'(qx_r) + CW'(ColsRight - 1)) begin
        px_r <= CW'(qx_r) - CW'(ColsLeft);
        py_r <= py_r + CW'(1);
      end else begin
        px_r <= px_r + CW'(1);
      end
    end
    x1_r <= ax; y1_r <= ay;
    x2_r <= x1_r; y2_r <= y1_r; rgb2_r <= rdata_r[95:72];
    s_s_r <= term_sum(rdata_r[95:72], ts_r);
    s_c_r <= term_sum(rdata_r[71:48], tc_r);
    s_p_r <= term_sum(rdata_r[47:24], tp_r);
    s_e_r <= term_sum(rdata_r[23:0],  te_r);
    x3_r <= x2_r; y3_r <= y2_r; rgb3_r <= rgb2_r;
    q_s_r <= s_s_r * s_s_r;
    q_c_r <= s_c_r * s_c_r;
    q_p_r <= s_p_r * s_p_r;
    q_e_r <= s_e_r * s_e_r;
    x4_r <= x3_r; y4_r <= y3_r; rgb4_r <= rgb3_r;
    e4_r <= ERRW'(q_s_r) + ERRW'(q_c_r * cfg_cw) + ERRW'(q_p_r * cfg_pw)
          + ERRW'(q_e_r * cfg_ew);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0; v2_r <= 1'b0; v3_r <= 1'b0; v4_r <= 1'b0;
      found_r <= 1'b0; fin_r <= 1'b0; out_valid <= 1'b0;
    end else begin
      v1_r <= cmd.rd && in_win;
      v2_r <= v1_r; v3_r <= v2_r; v4_r <= v3_r;
      fin_r <= cmd.fin_rd;
      out_valid <= cmd.done;
      if (cmd.init) found_r <= 1'b0;
      else if (v4_r && (!found_r || e4_r < best_r)) found_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (v4_r && (!found_r || e4_r < best_r)) begin
      best_r <= e4_r; bx_r <= x4_r; by_r <= y4_r; brgb_r <= rgb4_r;
    end
    if (fin_r && !found_r) brgb_r <= rdata_r[95:72];
    if (cmd.done) begin
      out_match_x     <= found_r ? 9'(bx_r) : 9'(qx_r);
      out_match_y     <= found_r ? 9'(by_r) : 9'(qy_r);
      out_match_rgb   <= brgb_r;
      out_match_error <= found_r ? best_r : ERR_INF;
    end
  end

endmodule

// ----- rtl/core/guided_window_match_search_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// guided_window_match_search_top
// Guided nearest-neighbour search of a source store over a clipped window.
// ----------------------------------------------------------------------------
// Load item: written to the source store, no result. Query item: 40 x 110 = 4400
// window positions scanned, one candidate per cycle from the single read port of
// the source store, then pipeline drain and result; one query at a time.
// Result strobe out_valid lasts one cycle; the receiver cannot stall.
// Synchronous active-low reset restores the register defaults; the source
// store is not cleared and reads undefined until written.
module guided_window_match_search_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic        in_operation,
  input  logic [8:0]  in_pixel_x,
  input  logic [8:0]  in_pixel_y,
  input  logic [23:0] in_style_rgb,
  input  logic [23:0] in_color_rgb,
  input  logic [23:0] in_position_rgb,
  input  logic [23:0] in_edge_rgb,
  output logic        out_valid,
  output logic [8:0]  out_match_x,
  output logic [8:0]  out_match_y,
  output logic [23:0] out_match_rgb,
  output logic [24:0] out_match_error,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [9:0]  cfg_data
);
  import gwms_pkg::*;

  gwms_cmd_t  cmd;
  gwms_sts_t  sts;
  logic [9:0] w_r, h_r;
  logic [3:0] cw_r, pw_r, ew_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w_r <= 10'd512; h_r <= 10'd512; cw_r <= 4'd7; pw_r <= 4'd1; ew_r <= 4'd2;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_WIDTH:  w_r  <= cfg_data;
        REG_HEIGHT: h_r  <= cfg_data;
        REG_CW:     cw_r <= cfg_data[3:0];
        REG_PW:     pw_r <= cfg_data[3:0];
        REG_EW:     ew_r <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  gwms_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .start(start), .in_operation(in_operation),
    .sts(sts), .cmd(cmd), .busy(busy)
  );

  gwms_dp u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts),
    .cfg_w(w_r), .cfg_h(h_r), .cfg_cw(cw_r), .cfg_pw(pw_r), .cfg_ew(ew_r),
    .in_pixel_x(in_pixel_x), .in_pixel_y(in_pixel_y),
    .in_style_rgb(in_style_rgb), .in_color_rgb(in_color_rgb),
    .in_position_rgb(in_position_rgb), .in_edge_rgb(in_edge_rgb),
    .out_valid(out_valid), .out_match_x(out_match_x), .out_match_y(out_match_y),
    .out_match_rgb(out_match_rgb), .out_match_error(out_match_error)
  );

endmodule
